// ===== hdl/asf_pkg.sv =====
// ---------------------------------------------------------------------------
// asf_pkg: shared types and constants of the autorange display formatter
// Segment patterns, digit codes, reciprocal constants and the structs that
// travel between the pipeline stages.
// ---------------------------------------------------------------------------
package asf_pkg;

	localparam int MV_W  = 16;
	localparam int N_W   = 11;
	localparam int SEG_W = 7;

	typedef logic [SEG_W-1:0] seg_t;
	typedef logic [1:0]       digit_idx_t;

	// segment pins are active low, all ones is a dark digit
	localparam seg_t SEG_BLANK = 7'h7F;

	// serializer word order
	localparam digit_idx_t DIG_HUND  = 2'd0;
	localparam digit_idx_t DIG_TENS  = 2'd1;
	localparam digit_idx_t DIG_UNITS = 2'd2;

	// digit position codes on the bus
	localparam logic [1:0] POS_HUND  = 2'd1;
	localparam logic [1:0] POS_TENS  = 2'd2;
	localparam logic [1:0] POS_UNITS = 2'd3;

	// range thresholds on the undoubled reading (v = 2 * mv)
	localparam logic [MV_W-1:0] MV_LOW_LIMIT = 16'd500;
	localparam logic [MV_W-1:0] MV_MID_LIMIT = 16'd5000;

	// reciprocals: mv/5 exact for mv < 16384, mv/50 exact for all 16-bit mv
	localparam logic [13:0] RCP_DIV5  = 14'd13108;
	localparam logic [16:0] RCP_DIV50 = 17'd83887;
	// n/100 exact for n < 4681, rest/10 exact for rest < 1024
	localparam logic [10:0] RCP_DIV100 = 11'd1311;
	localparam logic [7:0]  RCP_DIV10  = 8'd205;

	typedef struct packed {
		logic           point1;
		logic           point2;
		logic [N_W-1:0] n;
	} scaled_t;

	typedef struct packed {
		logic       point1;
		logic       point2;
		logic [3:0] hund;
		logic [6:0] rest;
	} split_t;

	typedef struct packed {
		logic       overflow;
		logic       point_level;
		logic [1:0] digit_position;
		seg_t       segment_levels;
	} result_t;

	// active-low pattern for one decimal digit
	function automatic seg_t seg_of(input logic [3:0] d);
		seg_t s;
		begin
			unique case (d)
				4'd0: s = 7'h08;
				4'd1: s = 7'h5B;
				4'd2: s = 7'h14;
				4'd3: s = 7'h11;
				4'd4: s = 7'h43;
				4'd5: s = 7'h21;
				4'd6: s = 7'h20;
				4'd7: s = 7'h1B;
				4'd8: s = 7'h00;
				4'd9: s = 7'h03;
				default: s = SEG_BLANK;
			endcase
			return s;
		end
	endfunction

endpackage

// ===== hdl/asf_scale.sv =====
// ---------------------------------------------------------------------------
// asf_scale: input register and range scaling
// Registers the reading, picks the range and scales the doubled reading to
// at most four decimal digits with reciprocal multiplies.
// ---------------------------------------------------------------------------
module asf_scale
	import asf_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [MV_W-1:0] in_mv,
	output logic            out_valid,
	input  logic            out_ready,
	output scaled_t         out_data
);

	logic            valid_s1;
	logic [MV_W-1:0] mv_s1;
	logic            valid_s2;
	scaled_t         scaled_s2;

	logic            adv_s1;
	logic            adv_s2;
	logic [29:0]     prod_div5;
	logic [32:0]     prod_div50;
	logic [MV_W:0]   v_dbl;
	scaled_t         scaled_d;

	// stage advance
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	// range pick: v/10 = mv/5, v/100 = mv/50
	always_comb begin
		v_dbl      = {mv_s1, 1'b0};
		prod_div5  = 30'(mv_s1 * RCP_DIV5);
		prod_div50 = 33'(mv_s1 * RCP_DIV50);
		scaled_d   = '{point1: 1'b1, point2: 1'b1, n: v_dbl[N_W-1:0]};
		if (mv_s1 >= MV_MID_LIMIT) begin
			scaled_d.point2 = 1'b0;
			scaled_d.n      = prod_div50[32:22];
		end else if (mv_s1 >= MV_LOW_LIMIT) begin
			scaled_d.point1 = 1'b0;
			scaled_d.n      = prod_div5[26:16];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && adv_s1) begin
			mv_s1 <= in_mv;
		end
		if (valid_s1 && adv_s2) begin
			scaled_s2 <= scaled_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = scaled_s2;

endmodule

// ===== hdl/asf_split.sv =====
// ---------------------------------------------------------------------------
// asf_split: hundreds split
// Takes the scaled value apart into the hundreds value and the remainder
// below one hundred.
// ---------------------------------------------------------------------------
module asf_split
	import asf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  scaled_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output split_t  out_data
);

	logic        valid_s3;
	split_t      split_s3;
	logic        adv_s3;
	logic [21:0] prod_div100;
	logic [3:0]  hund_d;
	logic [N_W-1:0] hund_x100;
	logic [N_W-1:0] rest_wide;

	assign adv_s3   = !valid_s3 || out_ready;
	assign in_ready = adv_s3;

	// hundreds by reciprocal, remainder by shift-add and subtract
	always_comb begin
		prod_div100 = 22'(in_data.n * RCP_DIV100);
		hund_d      = prod_div100[20:17];
		hund_x100   = {1'b0, hund_d, 6'b0} + {2'b0, hund_d, 5'b0} + {5'b0, hund_d, 2'b0};
		rest_wide   = in_data.n - hund_x100;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s3) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && adv_s3) begin
			split_s3 <= '{point1: in_data.point1, point2: in_data.point2,
				hund: hund_d, rest: rest_wide[6:0]};
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = split_s3;

endmodule

// ===== hdl/asf_digits.sv =====
// ---------------------------------------------------------------------------
// asf_digits: digit patterns and word serializer
// Splits the remainder into tens and units, looks up the three patterns,
// holds them in the result register and sends them as three words.
// ---------------------------------------------------------------------------
module asf_digits
	import asf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  split_t  in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data,
	output logic    out_last
);

	logic       valid_q;
	digit_idx_t cnt_q;
	seg_t       held_q;
	seg_t       seg0_q;
	seg_t       seg1_q;
	seg_t       seg2_q;
	logic       point1_q;
	logic       point2_q;
	logic       ovf_q;

	logic        take;
	logic        last_take;
	logic        load;
	logic [14:0] prod_div10;
	logic [3:0]  tens_d;
	logic [6:0]  tens_x10;
	logic [6:0]  units_wide;
	seg_t        seg0_d;
	seg_t        seg2_d;
	logic        ovf_d;

	assign take      = valid_q && out_ready;
	assign last_take = take && (cnt_q == DIG_UNITS);
	assign in_ready  = !valid_q || last_take;
	assign load      = in_valid && in_ready;

	// tens and units, overflowed hundreds repeats the held pattern
	always_comb begin
		prod_div10 = 15'(in_data.rest * RCP_DIV10);
		tens_d     = prod_div10[14:11];
		tens_x10   = {tens_d, 3'b0} + {2'b0, tens_d, 1'b0};
		units_wide = in_data.rest - tens_x10;
		ovf_d      = (in_data.hund > 4'd9);
		seg0_d     = ovf_d ? held_q : seg_of(in_data.hund);
		seg2_d     = seg_of(units_wide[3:0]);
	end

	// result register control and serializer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= DIG_HUND;
			held_q  <= SEG_BLANK;
		end else if (load) begin
			valid_q <= 1'b1;
			cnt_q   <= DIG_HUND;
			held_q  <= seg2_d;
		end else if (last_take) begin
			valid_q <= 1'b0;
		end else if (take) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			seg0_q   <= seg0_d;
			seg1_q   <= seg_of(tens_d);
			seg2_q   <= seg2_d;
			point1_q <= in_data.point1;
			point2_q <= in_data.point2;
			ovf_q    <= ovf_d;
		end
	end

	// word select
	always_comb begin
		out_data = '{overflow: 1'b0, point_level: 1'b1, digit_position: POS_UNITS,
			segment_levels: SEG_BLANK};
		out_last = 1'b0;
		unique case (cnt_q)
			DIG_HUND: begin
				out_data.segment_levels = seg0_q;
				out_data.digit_position = POS_HUND;
				out_data.point_level    = point1_q;
				out_data.overflow       = ovf_q;
			end
			DIG_TENS: begin
				out_data.segment_levels = seg1_q;
				out_data.digit_position = POS_TENS;
				out_data.point_level    = point2_q;
			end
			DIG_UNITS: begin
				out_data.segment_levels = seg2_q;
				out_data.digit_position = POS_UNITS;
				out_last                = 1'b1;
			end
			default: begin
				out_data.segment_levels = SEG_BLANK;
			end
		endcase
	end

	assign out_valid = valid_q;

`ifndef SYNTHESIS
	a_ovf_on_hund: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_data.overflow |-> out_data.digit_position == POS_HUND)
		else $error("overflow on a word other than hundreds");
	a_last_on_units: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> out_last == (out_data.digit_position == POS_UNITS))
		else $error("last word flag out of step with digit position");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q && $stable(cnt_q))
		else $error("serializer moved while stalled");
	a_held_tracks_units: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> held_q == seg2_q)
		else $error("held pattern differs from units pattern");
`endif

endmodule

// ===== hdl/autorange_seven_segment_formatter_top.sv =====
// ---------------------------------------------------------------------------
// autorange_seven_segment_formatter_top: three-digit autorange display words
// Turns a millivolt reading into three seven-segment words with range point.
// ---------------------------------------------------------------------------
// usage
//   s_* carries one reading per word: s_tdata[15:0] is millivolts.
//   m_* carries three words per reading: hundreds, tens, units, with tlast
//   high on the units word. each word holds the active-low segment levels,
//   the digit position (1..3), the active-low point and an overflow flag.
//   the point sits on digit 1 for 1000 <= 2*mv < 10000 and on digit 2
//   above that; an overflowed hundreds word repeats the last pattern driven.
// path: an accepted reading passes the input register, the scaling stage and
//   the hundreds split into the result register, which shows the hundreds word.
// words: the result register sends its three words one per cycle while
//   m_tready is high and loads the next reading as the units word is taken;
//   the stages in front keep taking readings while the result register drains.
// reset: arst_n clears every stage and sets the held pattern to all off.
// stall: with m_tready low the current word holds and the stages fill up;
//   s_tready drops once all three front stages hold a reading.
// ---------------------------------------------------------------------------
module autorange_seven_segment_formatter_top
	import asf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] millivolts
	output logic        m_tvalid,
	input  logic        m_tready,
	// [6:0] segment_levels, [8:7] digit_position, [9] point_level, [10] overflow
	output logic [15:0] m_tdata,
	output logic        m_tlast   // last_digit
);

	logic    scale_valid;
	logic    scale_ready;
	scaled_t scale_data;
	logic    split_valid;
	logic    split_ready;
	split_t  split_data;
	result_t result;

	// range pick and scaling
	asf_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mv     (s_tdata[MV_W-1:0]),
		.out_valid (scale_valid),
		.out_ready (scale_ready),
		.out_data  (scale_data)
	);

	// hundreds and remainder
	asf_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (scale_valid),
		.in_ready  (scale_ready),
		.in_data   (scale_data),
		.out_valid (split_valid),
		.out_ready (split_ready),
		.out_data  (split_data)
	);

	// patterns and word serializer
	asf_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (split_valid),
		.in_ready  (split_ready),
		.in_data   (split_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (result),
		.out_last  (m_tlast)
	);

	assign m_tdata = {5'b0, result};

endmodule

// ===== verif/autorange_seven_segment_formatter_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// autorange_seven_segment_formatter_checker: digit word prediction and compare
// Watches both stream channels of the formatter. Every accepted reading is
// turned into its hundreds, tens and units words by an independent model,
// and every word on the output is compared field by field with the oldest
// one still pending.
// ---------------------------------------------------------------------------
module autorange_seven_segment_formatter_checker
	import asf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] millivolts
	input  logic        m_tvalid,
	input  logic        m_tready,
	// [6:0] segment_levels, [8:7] digit_position, [9] point_level, [10] overflow
	input  logic [15:0] m_tdata,
	input  logic        m_tlast,  // last_digit
	output int          words_pending,
	output int          word_errors
);

	typedef struct packed {
		seg_t       segs;
		logic [1:0] pos;
		logic       point;
		logic       ovf;
		logic       last;
	} digit_word_t;

	digit_word_t pending_digit_words[$];
	seg_t        held_segments = SEG_BLANK;

	initial begin
		word_errors   = 0;
		words_pending = 0;
	end

	// active-low segment pattern of one decimal digit
	function automatic seg_t digit_pattern(input logic [3:0] d);
		seg_t p;
		case (d)
			4'd0: p = 7'h08;
			4'd1: p = 7'h5B;
			4'd2: p = 7'h14;
			4'd3: p = 7'h11;
			4'd4: p = 7'h43;
			4'd5: p = 7'h21;
			4'd6: p = 7'h20;
			4'd7: p = 7'h1B;
			4'd8: p = 7'h00;
			default: p = 7'h03;
		endcase
		return p;
	endfunction

	// scale the doubled reading and queue its three digit words
	function automatic void predict_reading_digits(input logic [15:0] mv);
		logic [16:0] v;
		logic [16:0] n;
		logic [16:0] hund;
		logic [16:0] tens;
		logic [16:0] units;
		logic        pt1;
		logic        pt2;
		digit_word_t w;
		v   = {mv, 1'b0};
		pt1 = 1'b1;
		pt2 = 1'b1;
		if (v < 17'd1000) begin
			n = v;
		end else if (v < 17'd10000) begin
			n   = v / 17'd10;
			pt1 = 1'b0;
		end else begin
			n   = v / 17'd100;
			pt2 = 1'b0;
		end
		hund  = n / 17'd100;
		tens  = (n % 17'd100) / 17'd10;
		units = n % 17'd10;

		// hundreds word, holds the last pattern when the value has no digit
		w.pos   = POS_HUND;
		w.point = pt1;
		w.last  = 1'b0;
		if (hund < 17'd10) begin
			w.segs        = digit_pattern(hund[3:0]);
			w.ovf         = 1'b0;
			held_segments = w.segs;
		end else begin
			w.segs = held_segments;
			w.ovf  = 1'b1;
		end
		pending_digit_words.push_back(w);

		// tens word
		w.segs        = digit_pattern(tens[3:0]);
		w.pos         = POS_TENS;
		w.point       = pt2;
		w.ovf         = 1'b0;
		w.last        = 1'b0;
		held_segments = w.segs;
		pending_digit_words.push_back(w);

		// units word closes the run
		w.segs        = digit_pattern(units[3:0]);
		w.pos         = POS_UNITS;
		w.point       = 1'b1;
		w.ovf         = 1'b0;
		w.last        = 1'b1;
		held_segments = w.segs;
		pending_digit_words.push_back(w);
	endfunction

	task automatic report_mismatch(input string what, input int want, input int got);
		$display("%0t: word mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want,
			got);
		word_errors++;
	endtask

	// compare one output word with the oldest pending one
	task automatic check_word();
		digit_word_t want;
		if (pending_digit_words.size() == 0) begin
			report_mismatch("unexpected word", 0, int'(m_tdata));
		end else begin
			want = pending_digit_words.pop_front();
			if (m_tdata[6:0] !== want.segs)
				report_mismatch("segment_levels", int'(want.segs), int'(m_tdata[6:0]));
			if (m_tdata[8:7] !== want.pos)
				report_mismatch("digit_position", int'(want.pos), int'(m_tdata[8:7]));
			if (m_tdata[9] !== want.point)
				report_mismatch("point_level", int'(want.point), int'(m_tdata[9]));
			if (m_tdata[10] !== want.ovf)
				report_mismatch("overflow", int'(want.ovf), int'(m_tdata[10]));
			if (m_tlast !== want.last)
				report_mismatch("last_digit", int'(want.last), int'(m_tlast));
			if (m_tdata[15:11] !== 5'd0)
				report_mismatch("tdata padding", 0, int'(m_tdata[15:11]));
		end
	endtask

	// sample both channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_segments = SEG_BLANK;
			pending_digit_words.delete();
			words_pending = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_word();
			if (s_tvalid && s_tready)
				predict_reading_digits(s_tdata);
			words_pending = pending_digit_words.size();
		end
	end

endmodule

// ===== verif/autorange_seven_segment_formatter_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// autorange_seven_segment_formatter_top_tb: stimulus and verdict
// Sends directed readings at the range edges and overflow, then random
// readings across all ranges under three idling patterns, with drain pauses
// between them. Word checking is done by the checker instance.
// ---------------------------------------------------------------------------
module autorange_seven_segment_formatter_top_tb;
	import asf_pkg::*;

	localparam int STALL_LIMIT   = 2000;
	localparam int PHASE_READS   = 167;
	localparam int DRAIN_CYCLES  = 20;
	localparam int DIRECTED_READS = 22;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;  // [15:0] millivolts
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [6:0] segment_levels, [8:7] digit_position, [9] point_level, [10] overflow
	logic [15:0] m_tdata;
	logic        m_tlast;  // last_digit

	int words_pending;
	int word_errors;
	int rx_idle      = 76;
	int stall_cycles = 0;

	always #5 clk = ~clk;

	autorange_seven_segment_formatter_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	autorange_seven_segment_formatter_checker word_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.words_pending (words_pending),
		.word_errors   (word_errors)
	);

	// random backpressure on the word side
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle);
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("autorange_seven_segment_formatter_top test failed");
			$finish;
		end
	end

	// offer one reading after a random gap, return once it is taken
	task automatic send_reading(input logic [15:0] mv, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= mv;
		do @(posedge clk); while (!s_tready);
	endtask

	// hold the reading side until every pending word has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		// let the checker log the reading taken at this edge first
		@(negedge clk);
		while (words_pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		logic [15:0] directed_mv [DIRECTED_READS];
		logic [15:0] mv;
		int          tx_idle;

		// overflow straight after reset, then range edges and mixed digits
		directed_mv = '{16'd65535, 16'd50000, 16'd0, 16'd1, 16'd499, 16'd500, 16'd501,
			16'd4999, 16'd5000, 16'd5001, 16'd49999, 16'd49950, 16'd50005, 16'd12345,
			16'd777, 16'd4444, 16'd9, 16'd45, 16'd250, 16'd3333, 16'd60000, 16'd32768};
		tx_idle = 31;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_READS; i++)
			send_reading(directed_mv[i], tx_idle);

		for (int phase = 0; phase < 3; phase++) begin
			wait_drained();
			case (phase)
				0: begin
					tx_idle = 31;
					rx_idle <= 76;
				end
				1: begin
					tx_idle = 76;
					rx_idle <= 31;
				end
				default: begin
					tx_idle = 0;
					rx_idle <= 0;
				end
			endcase
			for (int i = 0; i < PHASE_READS; i++) begin
				// spread readings over every display range
				case ($urandom_range(4))
					0: mv = 16'($urandom_range(499));
					1: mv = 16'($urandom_range(4999, 500));
					2: mv = 16'($urandom_range(49999, 5000));
					3: mv = 16'($urandom_range(65535, 50000));
					default: mv = 16'($urandom_range(65535));
				endcase
				send_reading(mv, tx_idle);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (word_errors == 0)
			$display("autorange_seven_segment_formatter_top test passed");
		else
			$display("autorange_seven_segment_formatter_top test failed");
		$finish;
	end

endmodule
